>>> sv/ssm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

  localparam int unsigned LenW      = 6;
  localparam int unsigned RegBytes  = 32;
  localparam int unsigned ByteIdxW  = 5;
  localparam int unsigned NumWords  = 4;
  localparam int unsigned WordW     = 64;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 40;
  localparam int unsigned OutPosW   = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic shift;
    logic fresh;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/ssm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ssm_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire ssm_pkg::cell_ctrl_t ctrl_i,
  input  wire  [7:0]               byte_i,
  input  wire  [7:0]               pat_byte_i,
  input  wire                      active_i,
  output logic [7:0]               byte_o,
  output logic                     eq_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = ctrl_i.fresh ? 8'd0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;
  assign eq_o   = !active_i || (byte_q == pat_byte_i);

endmodule

`default_nettype wire

>>> sv/ssm_align.sv
`timescale 1ns / 1ps
`default_nettype none

module ssm_align #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [ssm_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire  [ssm_pkg::WordW-1:0]            cfg_wdata_i,
  output logic [7:0]                           pat_o [PATTERN_MAX],
  output logic [PATTERN_MAX-1:0]               active_o,
  output logic [ssm_pkg::LenW-1:0]             len_o
);

  localparam int unsigned Cap = (PATTERN_MAX < ssm_pkg::RegBytes) ? PATTERN_MAX
                                                                  : ssm_pkg::RegBytes;

  logic [ssm_pkg::LenW-1:0]                      plen_q;
  logic [ssm_pkg::NumWords*ssm_pkg::WordW-1:0]   words_q;
  logic [7:0]                                    pat_q [PATTERN_MAX];
  logic [7:0]                                    pat_d [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]                        active_q, active_d;
  logic [ssm_pkg::LenW-1:0]                      len_q, len_d;
  logic [ssm_pkg::LenW-1:0]                      cap_len, zero_len;
  logic [ssm_pkg::LenW-1:0]                      sel [PATTERN_MAX];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q  <= '0;
      words_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ssm_pkg::REG_PATTERN_LENGTH: plen_q <= cfg_wdata_i[ssm_pkg::LenW-1:0];
        ssm_pkg::REG_PATTERN_WORD_0: words_q[0*ssm_pkg::WordW +: ssm_pkg::WordW] <= cfg_wdata_i;
        ssm_pkg::REG_PATTERN_WORD_1: words_q[1*ssm_pkg::WordW +: ssm_pkg::WordW] <= cfg_wdata_i;
        ssm_pkg::REG_PATTERN_WORD_2: words_q[2*ssm_pkg::WordW +: ssm_pkg::WordW] <= cfg_wdata_i;
        ssm_pkg::REG_PATTERN_WORD_3: words_q[3*ssm_pkg::WordW +: ssm_pkg::WordW] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective length: capacity limit, then the first zero byte
  always_comb begin
    cap_len  = (plen_q > ssm_pkg::LenW'(Cap)) ? ssm_pkg::LenW'(Cap) : plen_q;
    zero_len = ssm_pkg::LenW'(ssm_pkg::RegBytes);
    for (int i = ssm_pkg::RegBytes - 1; i >= 0; i--) begin
      if (words_q[i*8 +: 8] == 8'd0) begin
        zero_len = ssm_pkg::LenW'(i);
      end
    end
    len_d = (zero_len < cap_len) ? zero_len : cap_len;
  end

  // cell k faces pattern byte len-1-k
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      sel[k]      = len_d - ssm_pkg::LenW'(1) - ssm_pkg::LenW'(k);
      active_d[k] = (k < Cap) && (ssm_pkg::LenW'(k) < len_d);
      pat_d[k]    = active_d[k] ? words_q[sel[k][ssm_pkg::ByteIdxW-1:0]*8 +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      len_q    <= '0;
    end else begin
      active_q <= active_d;
      len_q    <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
  end

  assign pat_o    = pat_q;
  assign active_o = active_q;
  assign len_o    = len_q;

endmodule

`default_nettype wire

>>> sv/streaming_substring_matcher_unit.sv
// streaming_substring_matcher_unit
// finds the first occurrence of a loaded pattern (up to 32 bytes) in a byte stream
// configuration: cfg_we_i/cfg_index_i/cfg_wdata_i, index 0 pattern length,
//   indexes 1 to 4 pattern words 0 to 3; write only while the stream is idle
// input: s_axis_*, one text byte per beat in tdata, tlast marks the last byte
// output: m_axis_*, one beat per input beat, tdata holds found and the start
//   position of the first match, tlast copies the input tlast
// latency: a byte taken at edge n gives its result beat after edge n+1
// throughput: one byte per cycle, set by the compare across the row of window
//   cells and the sticky match stage that follows it
// text state (window, byte count, match flag) clears after the tlast beat
// reset clears the pattern registers, the window and all text state
// when m_axis_tready_i is low the output register holds its beat, the compare
//   stage holds the next one, and s_axis_tready_o drops once both are full
`timescale 1ns / 1ps
`default_nettype none

module streaming_substring_matcher_unit #(
  parameter int unsigned PATTERN_MAX    = 32,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [ssm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire  [ssm_pkg::WordW-1:0]         cfg_wdata_i,
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire  [ssm_pkg::InTdataW-1:0]      s_axis_tdata_i,   // text_byte
  input  wire                               s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  output logic [ssm_pkg::OutTdataW-1:0]     m_axis_tdata_o,   // found, match_position, zeros
  output logic                              m_axis_tlast_o
);

  localparam logic [POSITION_WIDTH-1:0] CountMax = {POSITION_WIDTH{1'b1}};

  logic [7:0]                  pat [PATTERN_MAX];
  logic [7:0]                  win [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]      active;
  logic [PATTERN_MAX-1:0]      eq;
  logic [ssm_pkg::LenW-1:0]    len;
  ssm_pkg::cell_ctrl_t         ctrl;
  ssm_pkg::cell_ctrl_t         ctrl_head;

  logic                        in_beat, out_ready, advance, hit;
  logic                        fresh_q, fresh_d;
  logic [POSITION_WIDTH-1:0]   count_q, count_d;
  logic                        s1_valid_q, s1_valid_d, s1_last_q, s1_first_q;
  logic                        seen_q, seen_prev, seen_new;
  logic [POSITION_WIDTH-1:0]   idx_q, idx_prev, idx_new, pos;
  logic                        out_valid_q, out_valid_d;
  logic                        out_found_q, out_last_q;
  logic [ssm_pkg::OutPosW-1:0] out_pos_q;

  ssm_align #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_align (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pat_o       (pat),
    .active_o    (active),
    .len_o       (len)
  );

  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || out_ready;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign advance         = s1_valid_q && out_ready;

  assign ctrl.shift      = in_beat;
  assign ctrl.fresh      = fresh_q;
  assign ctrl_head.shift = in_beat;
  assign ctrl_head.fresh = 1'b0;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      ssm_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl_head),
        .byte_i     (s_axis_tdata_i[7:0]),
        .pat_byte_i (pat[k]),
        .active_i   (active[k]),
        .byte_o     (win[k]),
        .eq_o       (eq[k])
      );
    end else begin : g_body
      ssm_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .byte_i     (win[k-1]),
        .pat_byte_i (pat[k]),
        .active_i   (active[k]),
        .byte_o     (win[k]),
        .eq_o       (eq[k])
      );
    end
  end

  always_comb begin
    count_d    = count_q;
    fresh_d    = fresh_q;
    s1_valid_d = s1_valid_q;
    if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (in_beat) begin
      fresh_d    = s_axis_tlast_i;
      s1_valid_d = 1'b1;
      if (fresh_q) begin
        count_d = POSITION_WIDTH'(1);
      end else if (count_q != CountMax) begin
        count_d = count_q + POSITION_WIDTH'(1);
      end
    end
  end

  // sticky first match
  always_comb begin
    hit       = &eq;
    pos       = (len == '0) ? '0 : count_q - POSITION_WIDTH'(len);
    seen_prev = s1_first_q ? 1'b0 : seen_q;
    idx_prev  = s1_first_q ? '0 : idx_q;
    seen_new  = seen_prev || hit;
    idx_new   = seen_prev ? idx_prev : (hit ? pos : '0);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= 1'b1;
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      seen_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fresh_q     <= fresh_d;
      count_q     <= count_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        seen_q <= seen_new;
        idx_q  <= idx_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_last_q  <= s_axis_tlast_i;
      s1_first_q <= fresh_q;
    end
    if (advance) begin
      out_found_q <= seen_new;
      out_pos_q   <= ssm_pkg::OutPosW'(idx_new);
      out_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(ssm_pkg::OutTdataW - ssm_pkg::OutPosW - 1){1'b0}},
                            out_pos_q, out_found_q};

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> s1_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled while a stage is free");

  a_hit_needs_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && hit && (len != '0) |-> count_q >= POSITION_WIDTH'(len))
    else $error("match reported before enough bytes were seen");

  a_new_text_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && fresh_q |=> count_q == POSITION_WIDTH'(1))
    else $error("byte count not restarted at a new text");

  a_empty_pattern_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (len == '0) |=> out_found_q && (out_pos_q == '0 || !$past(s1_first_q)))
    else $error("empty pattern not matched at the first byte");
`endif

endmodule

`default_nettype wire
